/* rtl/core/rvml_pkg.sv */
// ---------------------------------------------------------------------------
// rvml_pkg
// Shared types and constants of the rail voltage monitor with flap lockout.
// ---------------------------------------------------------------------------
package rvml_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;

  localparam int DEF_AVERAGE_DEPTH = 20;
  localparam int DEF_BANK_COUNT    = 2;

  localparam logic [SAMPLE_W-1:0] RST_HIGH_THR    = 16'd10500;
  localparam logic [SAMPLE_W-1:0] RST_LOW_THR     = 16'd3000;
  localparam logic                RST_SERVO_LOCK  = 1'b0;
  localparam logic [15:0]         RST_FLAP_WINDOW = 16'd200;
  localparam logic [15:0]         RST_LOCKOUT     = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR    = 3'd0,
    CFG_LOW_THR     = 3'd1,
    CFG_SERVO_LOCK  = 3'd2,
    CFG_FLAP_WINDOW = 3'd3,
    CFG_LOCKOUT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [CODE_W-1:0] {
    STATUS_NONE        = 2'd0,
    STATUS_HIGH        = 2'd1,
    STATUS_LOW         = 2'd2,
    STATUS_HIGH_LOCKED = 2'd3
  } status_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_thr;
    logic [SAMPLE_W-1:0] low_thr;
    logic                servo_lock;
    logic [15:0]         flap_window;
    logic [15:0]         lockout;
  } cfg_t;

  // Per-item control toward the sample ring
  typedef struct packed {
    logic take;     // item leaves the input stage this cycle
    logic discard;  // lockout active: leave the ring untouched
  } ring_ctrl_t;

  typedef struct packed {
    status_e code;
    logic    locked_out;
    logic    power_change;
  } res_t;

endpackage

/* rtl/core/rvml_ring.sv */
// ---------------------------------------------------------------------------
// rvml_ring
// Per-bank sample ring with exact running sum and constant-divide average.
// ---------------------------------------------------------------------------
module rvml_ring
  import rvml_pkg::*;
#(
  parameter int AVERAGE_DEPTH = DEF_AVERAGE_DEPTH,
  parameter int BANK_COUNT    = DEF_BANK_COUNT,
  localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [BANK_W-1:0]   rd_bank_i,
  input  ring_ctrl_t          ctrl_i,
  input  logic [BANK_W-1:0]   bank_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SAMPLE_W-1:0] avg_o
);

  localparam int POS_W  = $clog2(AVERAGE_DEPTH);
  localparam int SUM_W  = SAMPLE_W + $clog2(AVERAGE_DEPTH);
  localparam int DIV_K  = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int DIV_M  = ((1 << DIV_K) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
  localparam int M_W    = DIV_K + 1;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [M_W-1:0]   DIV_M_C = M_W'(DIV_M);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVERAGE_DEPTH - 1);

  logic [SAMPLE_W-1:0]      mem_q [BANK_COUNT][AVERAGE_DEPTH];
  logic [AVERAGE_DEPTH-1:0] vld_q [BANK_COUNT];
  logic [POS_W-1:0]         pos_q [BANK_COUNT];
  logic [POS_W-1:0]         pos_d [BANK_COUNT];
  logic [SUM_W-1:0]         sum_q [BANK_COUNT];
  logic [SUM_W-1:0]         sum_d [BANK_COUNT];

  logic [SAMPLE_W-1:0] old_q;
  logic                old_vld_q;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    new_sum;
  logic [SUM_W-1:0]    div_in;
  logic [PROD_W-1:0]   prod;
  logic                push;
  logic [POS_W-1:0]    rd_pos;

  assign push       = ctrl_i.take & ~ctrl_i.discard;
  assign old_sample = old_vld_q ? old_q : '0;
  assign new_sum    = sum_q[bank_i] - SUM_W'(old_sample) + SUM_W'(sample_i);
  assign div_in     = ctrl_i.discard ? sum_q[bank_i] : new_sum;

  // floor(sum / depth) via reciprocal; exact over the whole sum range
  assign prod  = PROD_W'(div_in) * PROD_W'(DIV_M_C);
  assign avg_o = prod[DIV_K +: SAMPLE_W];

  always_comb begin
    for (int b = 0; b < BANK_COUNT; b++) begin
      pos_d[b] = pos_q[b];
      sum_d[b] = sum_q[b];
      if (push && (bank_i == BANK_W'(b))) begin
        pos_d[b] = (pos_q[b] == POS_LAST) ? '0 : pos_q[b] + 1'b1;
        sum_d[b] = new_sum;
      end
    end
  end

  // Forward the advancing position so the read lines up with the next push
  assign rd_pos = pos_d[rd_bank_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '{default: '0};
      sum_q <= '{default: '0};
      vld_q <= '{default: '0};
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (push) begin
        vld_q[bank_i][pos_q[bank_i]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[bank_i][pos_q[bank_i]] <= sample_i;
    end
    if (rd_en_i) begin
      old_q     <= mem_q[rd_bank_i][rd_pos];
      old_vld_q <= vld_q[rd_bank_i][rd_pos];
    end
  end

  for (genvar g = 0; g < BANK_COUNT; g++) begin : g_chk
    a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pos_q[g] <= POS_LAST)
      else $error("ring position out of range");
  end

endmodule

/* rtl/core/rvml_flap_ctrl.sv */
// ---------------------------------------------------------------------------
// rvml_flap_ctrl
// Average classification, flap detection and lockout timing.
// ---------------------------------------------------------------------------
module rvml_flap_ctrl
  import rvml_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic [SAMPLE_W-1:0] avg_i,
  input  cfg_t                cfg_i,
  output logic                lock_o,
  output res_t                res_o
);

  logic [TIME_W-1:0] last_high_q, last_high_d;
  logic [TIME_W-1:0] last_low_q, last_low_d;
  logic              high_seen_q, high_seen_d;
  logic              low_seen_q, low_seen_d;
  logic              lock_q, lock_d;
  logic [TIME_W-1:0] start_q, start_d;

  logic [TIME_W-1:0] dl, dh, dlock;
  logic              flap, expired, is_high;

  assign dl      = now_i - last_low_q;
  assign dh      = now_i - last_high_q;
  assign dlock   = now_i - start_q;
  assign expired = dlock > TIME_W'(cfg_i.lockout);
  assign flap    = high_seen_q && low_seen_q && (dl != '0) && (dh != '0) &&
                   (dl < TIME_W'(cfg_i.flap_window)) && (dh < TIME_W'(cfg_i.flap_window));
  assign is_high = avg_i > cfg_i.high_thr;

  always_comb begin
    last_high_d = last_high_q;
    last_low_d  = last_low_q;
    high_seen_d = high_seen_q;
    low_seen_d  = low_seen_q;
    lock_d      = lock_q;
    start_d     = start_q;
    res_o.code  = STATUS_NONE;
    if (lock_q) begin
      res_o.locked_out   = ~expired;
      res_o.power_change = expired;
      if (fire_i) begin
        lock_d = ~expired;
      end
    end else begin
      res_o.locked_out   = flap;
      res_o.power_change = flap;
      if (is_high) begin
        res_o.code = cfg_i.servo_lock ? STATUS_HIGH_LOCKED : STATUS_HIGH;
      end else if ((avg_i < cfg_i.low_thr) && !cfg_i.servo_lock) begin
        res_o.code = STATUS_LOW;
      end
      if (fire_i) begin
        if (flap) begin
          lock_d  = 1'b1;
          start_d = now_i;
        end
        if (is_high) begin
          last_high_d = now_i;
          high_seen_d = 1'b1;
        end else begin
          // every non-high average counts as low for flap tracking
          last_low_d = now_i;
          low_seen_d = 1'b1;
        end
      end
    end
  end

  assign lock_o = lock_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_high_q <= '0;
      last_low_q  <= '0;
      high_seen_q <= 1'b0;
      low_seen_q  <= 1'b0;
      lock_q      <= 1'b0;
      start_q     <= '0;
    end else begin
      last_high_q <= last_high_d;
      last_low_q  <= last_low_d;
      high_seen_q <= high_seen_d;
      low_seen_q  <= low_seen_d;
      lock_q      <= lock_d;
      start_q     <= start_d;
    end
  end

  a_lock_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !lock_q && flap |=> lock_q && (start_q == $past(now_i)))
    else $error("lockout entry did not latch start time");

  a_lock_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lock_q) |-> $past(fire_i) && $past(expired))
    else $error("lockout left without an expired item");

endmodule

/* rtl/core/rail_voltage_monitor_lockout.sv */
// ---------------------------------------------------------------------------
// rail_voltage_monitor_lockout
// Two-bank rail voltage moving-average monitor with flap lockout.
// ---------------------------------------------------------------------------
// Usage:
//   Send one beat per rail sample on the s_axis channel: tuser carries the
//   bank, tdata the sample and the current millisecond time. Every input
//   beat yields exactly one m_axis beat with the status code, the bank's
//   moving average, the lockout flag and the power change flag.
//   Thresholds, servo lock, flap window and lockout time are written over
//   the cfg channel (always ready); write them only while the block is idle.
// Timing:
//   One beat per cycle sustained while m_axis_tready stays high. A result
//   beat passes two registers: the accepting edge loads the input stage
//   (which also reads the old ring sample from memory), and the result
//   register is loaded when the input stage advances.
//   The ring sum update, reciprocal multiply for the average and the
//   threshold compares sit between those two registers.
// Reset:
//   rst_ni clears the sample rings (via per-entry valid bits), sums,
//   positions, flap history and lockout state, and reloads register defaults.
// Backpressure:
//   When m_axis_tready is low, the result register holds, the input stage
//   keeps one more beat, and s_axis_tready drops until the result drains.
// ---------------------------------------------------------------------------
module rail_voltage_monitor_lockout
  import rvml_pkg::*;
#(
  parameter int AVERAGE_DEPTH = DEF_AVERAGE_DEPTH,
  parameter int BANK_COUNT    = DEF_BANK_COUNT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample_mv, [47:16] now_ms
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] bank
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] status_code, [17:2] average_mv,
                                                 // [18] locked_out, [19] power_change,
                                                 // [23:20] zero
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  // Input stage
  logic                s1_valid_q, s1_valid_d;
  logic [BANK_W-1:0]   s1_bank_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [TIME_W-1:0]   s1_now_q;
  logic                s1_fire;
  logic                in_beat;
  logic [BANK_W-1:0]   in_bank;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [SAMPLE_W-1:0] avg;
  logic                lock;
  res_t                res;
  ring_ctrl_t          ring_ctrl;

  // Banks above the count wrap; the one-bit bank field only needs folding
  // when a single bank is built.
  assign in_bank = (BANK_COUNT == 1) ? '0 : BANK_W'(s_axis_tuser[0]);

  // Advance the input stage whenever the result register is free or draining
  assign s1_fire       = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_fire;
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign s1_valid_d    = in_beat | (s1_valid_q & ~s1_fire);
  assign out_valid_d   = s1_fire | (out_valid_q & ~m_axis_tready);

  assign ring_ctrl.take    = s1_fire;
  assign ring_ctrl.discard = lock;

  // Config writes: always taken, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HIGH_THR:    cfg_d.high_thr    = cfg_data_i;
        CFG_LOW_THR:     cfg_d.low_thr     = cfg_data_i;
        CFG_SERVO_LOCK:  cfg_d.servo_lock  = cfg_data_i[0];
        CFG_FLAP_WINDOW: cfg_d.flap_window = cfg_data_i;
        CFG_LOCKOUT:     cfg_d.lockout     = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  rvml_ring #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH),
    .BANK_COUNT    (BANK_COUNT)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_beat),
    .rd_bank_i (in_bank),
    .ctrl_i    (ring_ctrl),
    .bank_i    (s1_bank_q),
    .sample_i  (s1_sample_q),
    .avg_o     (avg)
  );

  rvml_flap_ctrl u_flap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .now_i  (s1_now_q),
    .avg_i  (avg),
    .cfg_i  (cfg_q),
    .lock_o (lock),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr    <= RST_HIGH_THR;
      cfg_q.low_thr     <= RST_LOW_THR;
      cfg_q.servo_lock  <= RST_SERVO_LOCK;
      cfg_q.flap_window <= RST_FLAP_WINDOW;
      cfg_q.lockout     <= RST_LOCKOUT;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold unless a beat moves in
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_bank_q   <= in_bank;
      s1_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      s1_now_q    <= s_axis_tdata[SAMPLE_W +: TIME_W];
    end
    if (s1_fire) begin
      out_data_q <= {4'b0000, res.power_change, res.locked_out, avg, res.code};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A steady lockout beat never reports a classification
  a_locked_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18] && !m_axis_tdata[19] |->
      (m_axis_tdata[1:0] == STATUS_NONE))
    else $error("nonzero status during steady lockout");

endmodule
